// ===== rtl/pbld_pkg.sv =====
// types and constants shared by the packbits line decoder
`default_nettype none

package pbld_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } t_phase;

    localparam logic [7:0] SKIP_CODE = 8'h80;
    localparam logic [8:0] REPEAT_BASE = 9'd257;

    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LINE_WIDTH = 1'b0;
    localparam t_cfg_idx CFG_LINE_COUNT = 1'b1;

    localparam logic [15:0] LINE_WIDTH_RST = 16'd320;
    localparam logic [15:0] LINE_COUNT_RST = 16'd200;

endpackage

`default_nettype wire

// ===== rtl/packbits_line_decoder.sv =====
// packbits line decoder top level
//
// input channel: one compressed stream byte per transfer (i_valid, o_stall,
// i_data_byte). header bytes produce no result; each literal or repeat value
// byte produces one result describing the pixels it writes.
// output channel: o_valid, i_stall and the result fields, held in one output
// register.
// a result is registered and is visible in the cycle after its byte transfers.
// throughput: one byte per cycle while o_stall is low; a new byte is taken in the same cycle the
// waiting result is taken, since decode state and the output register update
// together on each transfer.
// when the receiver stalls with a result pending, o_stall rises and the input
// waits; a header byte is never taken while a result is stuck.
// configuration: i_cfg_we writes line_width (index 0) or line_count (index 1)
// at once; the user makes writes while the block is idle; it is not enforced.
// reset (synchronous, active low): header phase, column and row zero,
// line_width 320, line_count 200, output register empty.
`default_nettype none

module packbits_line_decoder (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire pbld_pkg::t_cfg_idx    i_cfg_idx,
    input  wire logic [15:0]           i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_data_byte,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [7:0]                 o_pixel_value,
    output logic [7:0]                 o_run_length,
    output logic [15:0]                o_column,
    output logic [15:0]                o_row,
    output logic                       o_line_done,
    output logic                       o_image_done
);

    logic [15:0]      r_line_width;
    logic [15:0]      r_line_count;
    pbld_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_bytes_left, n_bytes_left;
    logic [15:0]      r_col, n_col;
    logic [15:0]      r_row, n_row;

    logic        r_out_valid;
    logic [7:0]  r_pixel_value;
    logic [7:0]  r_run_length;
    logic [15:0] r_column;
    logic [15:0] r_row_out;
    logic        r_line_done;
    logic        r_image_done;

    logic        in_xfer;
    logic        has_result;
    logic [7:0]  run_len;
    logic [15:0] room;
    logic [7:0]  used;
    logic        full;
    logic        last;
    logic [15:0] row_inc;
    logic [8:0]  rep_count;

    assign o_stall = r_out_valid && i_stall;
    assign in_xfer = i_valid && !o_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= pbld_pkg::LINE_WIDTH_RST;
            r_line_count <= pbld_pkg::LINE_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pbld_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                pbld_pkg::CFG_LINE_COUNT: r_line_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // run clipping against the line end
    always_comb begin
        run_len = (r_phase == pbld_pkg::PH_REPEAT) ? r_bytes_left : 8'd1;
        room = (r_col >= r_line_width) ? 16'd1 : (r_line_width - r_col);
        used = ({8'd0, run_len} < room) ? run_len : room[7:0];
        full = ({8'd0, used} == room);
        row_inc = r_row + 16'd1;
        last = full && ((row_inc >= r_line_count) || (row_inc == 16'd0));
        rep_count = pbld_pkg::REPEAT_BASE - {1'b0, i_data_byte};
    end

    // decode state next values
    always_comb begin
        n_phase = r_phase;
        n_bytes_left = r_bytes_left;
        n_col = r_col;
        n_row = r_row;
        has_result = 1'b0;
        case (r_phase)
            pbld_pkg::PH_LITERAL: begin
                has_result = 1'b1;
                n_bytes_left = r_bytes_left - 8'd1;
                if (n_bytes_left == 8'd0) begin
                    n_phase = pbld_pkg::PH_HEADER;
                end
            end
            pbld_pkg::PH_REPEAT: begin
                has_result = 1'b1;
                n_phase = pbld_pkg::PH_HEADER;
                n_bytes_left = 8'd0;
            end
            default: begin
                n_phase = pbld_pkg::PH_HEADER;
                if (i_data_byte == pbld_pkg::SKIP_CODE) begin
                    n_phase = pbld_pkg::PH_HEADER;
                end else if (i_data_byte < pbld_pkg::SKIP_CODE) begin
                    n_phase = pbld_pkg::PH_LITERAL;
                    n_bytes_left = i_data_byte + 8'd1;
                end else begin
                    n_phase = pbld_pkg::PH_REPEAT;
                    n_bytes_left = rep_count[7:0];
                end
            end
        endcase
        if (has_result) begin
            if (full) begin
                n_col = 16'd0;
                n_phase = pbld_pkg::PH_HEADER;
                n_bytes_left = 8'd0;
                n_row = last ? 16'd0 : row_inc;
            end else begin
                n_col = r_col + {8'd0, used};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pbld_pkg::PH_HEADER;
            r_bytes_left <= 8'd0;
            r_col <= 16'd0;
            r_row <= 16'd0;
        end else if (in_xfer) begin
            r_phase <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && has_result) begin
            r_pixel_value <= i_data_byte;
            r_run_length <= used;
            r_column <= r_col;
            r_row_out <= r_row;
            r_line_done <= full;
            r_image_done <= last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel_value = r_pixel_value;
    assign o_run_length = r_run_length;
    assign o_column = r_column;
    assign o_row = r_row_out;
    assign o_line_done = r_line_done;
    assign o_image_done = r_image_done;

`ifndef SYNTHESIS
    a_image_implies_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_image_done |-> o_line_done)
        else $error("image_done without line_done");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_run_length != 8'd0))
        else $error("zero run length");

    a_line_done_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_done |-> (r_col == 16'd0))
        else $error("column not cleared after line end");

    a_col_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_line_done |-> (r_col == o_column + {8'd0, o_run_length}))
        else $error("column did not advance by run length");

    a_repeat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pbld_pkg::PH_REPEAT |-> (r_bytes_left >= 8'd2 && r_bytes_left <= 8'd128))
        else $error("repeat count out of range");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_packbits_line_decoder.sv =====
// testbench for the packbits line decoder: random byte streams in, predicted pixel runs checked out
`default_nettype none

module tb_packbits_line_decoder;

    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [7:0]  run_length;
        logic [15:0] column;
        logic [15:0] row;
        logic        line_done;
        logic        image_done;
    } t_run;

    class run_tracker;
        pbld_pkg::t_phase phase;
        logic [7:0]       bytes_left;
        logic [15:0]      column_pos;
        logic [15:0]      row_pos;
        logic [15:0]      line_width;
        logic [15:0]      line_count;
        t_run             runs_owed[$];
        int               errors;

        function new();
            phase = pbld_pkg::PH_HEADER;
            bytes_left = '0;
            column_pos = '0;
            row_pos = '0;
            line_width = pbld_pkg::LINE_WIDTH_RST;
            line_count = pbld_pkg::LINE_COUNT_RST;
            errors = 0;
        endfunction

        function int pending();
            return runs_owed.size();
        endfunction

        function void set_reg(pbld_pkg::t_cfg_idx idx, logic [15:0] val);
            if (idx == pbld_pkg::CFG_LINE_WIDTH) begin
                line_width = val;
            end else begin
                line_count = val;
            end
        endfunction

        // pixels written by one data byte, clipped at the line end
        function void put_run(logic [7:0] value, logic [7:0] len);
            logic [16:0] room;
            logic [16:0] used;
            logic        full;
            logic        last;
            t_run        r;
            last = 1'b0;
            if (column_pos >= line_width) begin
                room = 17'd1;
            end else begin
                room = {1'b0, line_width} - {1'b0, column_pos};
            end
            used = ({9'd0, len} < room) ? {9'd0, len} : room;
            full = (used == room);
            r.pixel_value = value;
            r.run_length = used[7:0];
            r.column = column_pos;
            r.row = row_pos;
            if (full) begin
                column_pos = '0;
                phase = pbld_pkg::PH_HEADER;
                bytes_left = '0;
                row_pos = row_pos + 16'd1;
                if (row_pos >= line_count || row_pos == 16'd0) begin
                    last = 1'b1;
                    row_pos = '0;
                end
            end else begin
                column_pos = column_pos + used[15:0];
            end
            r.line_done = full;
            r.image_done = last;
            runs_owed = {runs_owed, r};
        endfunction

        function void take_byte(logic [7:0] b);
            logic [7:0] cnt;
            case (phase)
                pbld_pkg::PH_LITERAL: begin
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0) begin
                        phase = pbld_pkg::PH_HEADER;
                    end
                    put_run(b, 8'd1);
                end
                pbld_pkg::PH_REPEAT: begin
                    cnt = bytes_left;
                    phase = pbld_pkg::PH_HEADER;
                    bytes_left = '0;
                    put_run(b, cnt);
                end
                default: begin
                    phase = pbld_pkg::PH_HEADER;
                    if (b == pbld_pkg::SKIP_CODE) begin
                        phase = pbld_pkg::PH_HEADER;
                    end else if (b < pbld_pkg::SKIP_CODE) begin
                        phase = pbld_pkg::PH_LITERAL;
                        bytes_left = b + 8'd1;
                    end else begin
                        phase = pbld_pkg::PH_REPEAT;
                        bytes_left = 8'(pbld_pkg::REPEAT_BASE - {1'b0, b});
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task cmp(string name, int unsigned got, int unsigned want);
            if (got != want) begin
                report($sformatf("%s got %0d want %0d", name, got, want));
            end
        endtask

        task check_run(t_run got);
            t_run want;
            if (runs_owed.size() == 0) begin
                report($sformatf("run with none owed: value %0d col %0d row %0d",
                                 got.pixel_value, got.column, got.row));
            end else begin
                want = runs_owed.pop_front();
                cmp("pixel_value", got.pixel_value, want.pixel_value);
                cmp("run_length", got.run_length, want.run_length);
                cmp("column", got.column, want.column);
                cmp("row", got.row, want.row);
                cmp("line_done", got.line_done, want.line_done);
                cmp("image_done", got.image_done, want.image_done);
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    pbld_pkg::t_cfg_idx  i_cfg_idx = pbld_pkg::CFG_LINE_WIDTH;
    logic [15:0]         i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [7:0]          i_data_byte = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [7:0]          o_pixel_value;
    logic [7:0]          o_run_length;
    logic [15:0]         o_column;
    logic [15:0]         o_row;
    logic                o_line_done;
    logic                o_image_done;

    int          idle_pct = 10;
    int          stall_pct = 10;
    int          quiet = 0;
    run_tracker  sb;

    packbits_line_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_value (o_pixel_value),
        .o_run_length  (o_run_length),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_line_done   (o_line_done),
        .o_image_done  (o_image_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stall, check every transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_run({o_pixel_value, o_run_length, o_column, o_row,
                          o_line_done, o_image_done});
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sb.take_byte(b);
    endtask

    task automatic wait_all_runs();
        i_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input pbld_pkg::t_cfg_idx idx, input logic [15:0] val);
        wait_all_runs();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_list(input logic [7:0] bytes[]);
        foreach (bytes[k]) begin
            send_byte(bytes[k]);
        end
    endtask

    // mostly well-formed literal and repeat runs, some skips and stray bytes
    task automatic send_stream(input int n);
        int sent;
        int kind;
        int len;
        int k;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(99);
            if (kind < 45 && n - sent >= 2) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 128)
                                               : $urandom_range(1, 8);
                if (len > n - sent - 1) begin
                    len = n - sent - 1;
                end
                send_byte(8'(len - 1));
                for (k = 0; k < len; k++) begin
                    send_byte(8'($urandom));
                end
                sent += len + 1;
            end else if (kind < 85 && n - sent >= 2) begin
                len = $urandom_range(2, 128);
                send_byte(8'(257 - len));
                send_byte(8'($urandom));
                sent += 2;
            end else if (kind < 90) begin
                send_byte(pbld_pkg::SKIP_CODE);
                sent += 1;
            end else begin
                send_byte(8'($urandom));
                sent += 1;
            end
        end
    endtask

    initial begin
        int unsigned widths[7];
        int unsigned counts[7];
        int          sizes[7];
        int          p;
        widths = '{1, 2, 7, 65535, 130, 0, 3};
        counts = '{1, 3, 5, 65535, 2, 0, 65535};
        sizes = '{150, 150, 160, 100, 160, 150, 150};
        widths[5] = $urandom_range(1, 40);
        counts[5] = $urandom_range(1, 6);
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: literal, repeat, skip, fills mid-run, image wrap
        write_reg(pbld_pkg::CFG_LINE_WIDTH, 16'd4);
        write_reg(pbld_pkg::CFG_LINE_COUNT, 16'd2);
        send_list('{8'h00, 8'h11, 8'hFF, 8'h22, pbld_pkg::SKIP_CODE, 8'h7F, 8'h33,
                    8'h81, 8'hAA, 8'h01, 8'h55, 8'h5A});
        // width and count lowered below the current position
        write_reg(pbld_pkg::CFG_LINE_WIDTH, 16'd1);
        send_list('{8'h00, 8'h66});
        write_reg(pbld_pkg::CFG_LINE_COUNT, 16'd1);
        send_list('{8'hFE, 8'h77});
        write_reg(pbld_pkg::CFG_LINE_WIDTH, 16'd0);
        write_reg(pbld_pkg::CFG_LINE_COUNT, 16'd0);
        send_list('{8'h02, 8'h01, pbld_pkg::SKIP_CODE, 8'hFF, 8'h7E});
        write_reg(pbld_pkg::CFG_LINE_WIDTH, 16'hFFFF);
        write_reg(pbld_pkg::CFG_LINE_COUNT, 16'hFFFF);
        send_list('{8'h00, 8'h01, 8'hFD, 8'hE3});

        for (p = 0; p < 7; p++) begin
            write_reg(pbld_pkg::CFG_LINE_WIDTH, 16'(widths[p]));
            write_reg(pbld_pkg::CFG_LINE_COUNT, 16'(counts[p]));
            idle_pct = (p == 2) ? 0 : 10;
            stall_pct = (p == 2) ? 0 : 10;
            send_stream(sizes[p] / 2);
            wait_all_runs();
            send_stream(sizes[p] - sizes[p] / 2);
        end

        wait_all_runs();
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
